/* rtl/fct_pkg.sv */
// shared types, sizes and operation codes for the fat16 cluster table
package fct_pkg;

    // table geometry
    localparam int TABLE_DEPTH   = 4096;
    localparam int ADDR_W        = $clog2(TABLE_DEPTH);
    localparam int LIM_W         = ADDR_W + 1;
    localparam int DATA_W        = 16;
    localparam int CFG_W         = 13;
    localparam int CMP_W         = 17;
    localparam int RESET_ENTRIES = 4096;
    localparam int RESET_LIM_I   = (RESET_ENTRIES < TABLE_DEPTH) ? RESET_ENTRIES : TABLE_DEPTH;
    localparam logic [LIM_W-1:0] RESET_LIM = LIM_W'(RESET_LIM_I);

    // entry codes
    localparam logic [DATA_W-1:0] END_OF_CHAIN = 16'hFFFF;

    // operation codes
    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_ALLOC = 2'd1;
    localparam logic [1:0] FUNC_NEXT  = 2'd2;

    // input item
    typedef struct packed {
        logic [1:0]        func;
        logic [DATA_W-1:0] entry_index;
        logic [DATA_W-1:0] entry_value;
        logic [DATA_W-1:0] link_from;
    } t_in_item;

    // result item
    typedef struct packed {
        logic [DATA_W-1:0] cluster_out;
        logic              success;
    } t_out_item;

endpackage

/* rtl/fct_ram.sv */
// simple dual-port synchronous ram with registered read data
module fct_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, read data registered
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

/* rtl/fat16_cluster_table.sv */
// top level of the fat16 cluster table: sequencer, limit register and output stage
//
// The table lives in one simple dual-port RAM of 4096 16-bit entries with a
// registered read; one item is worked at a time. An allocate scans from entry
// 0 up to the first free entry, or to the end of the active range when the
// table is full, reading one entry per cycle through the single read port. A
// new item is accepted while the previous result waits at the output register.
// Entries are undefined after reset: load the table before allocating or
// following chains. entries_in_use may be written whenever the block is idle;
// values above the table depth act as the depth.
module fat16_cluster_table
    import fct_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_in_item         i_item,
    output logic             o_valid,
    input  logic             i_ready,
    output t_out_item        o_item,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_NRD   = 3'd2;
    localparam logic [2:0] S_NWAIT = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_LINK  = 3'd5;
    localparam logic [2:0] S_MARK  = 3'd6;
    localparam logic [2:0] S_RESP  = 3'd7;

    logic [2:0]        r_state, n_state;
    logic [LIM_W-1:0]  r_lim;
    t_in_item          r_item;
    logic [LIM_W-1:0]  r_scan, n_scan;
    logic              r_pend, n_pend;
    logic [ADDR_W-1:0] r_pend_addr, n_pend_addr;
    logic [ADDR_W-1:0] r_hit, n_hit;
    logic [DATA_W-1:0] r_res, n_res;
    logic              r_ok, n_ok;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out_item, n_out_item;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    logic              accept;
    logic              issue;
    logic              idx_in_table;
    logic              idx_in_lim;
    logic              link_ok;
    logic [CMP_W-1:0]  lim_ext;
    logic [CMP_W-1:0]  cfg_lim;

    assign accept  = i_valid && o_ready;
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;
    assign o_item  = r_out_item;

    // range checks against table depth and active limit
    assign lim_ext      = CMP_W'(r_lim);
    assign idx_in_table = CMP_W'(r_item.entry_index) < CMP_W'(TABLE_DEPTH);
    assign idx_in_lim   = CMP_W'(r_item.entry_index) < lim_ext;
    assign link_ok      = (r_item.link_from != '0) && (CMP_W'(r_item.link_from) < lim_ext);
    assign issue        = CMP_W'(r_scan) < lim_ext;

    // active limit is entries_in_use clipped to the table depth
    assign cfg_lim = (CMP_W'(i_cfg_data) > CMP_W'(TABLE_DEPTH))
                   ? CMP_W'(TABLE_DEPTH) : CMP_W'(i_cfg_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim <= RESET_LIM;
        end else if (i_cfg_we) begin
            r_lim <= cfg_lim[LIM_W-1:0];
        end
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

    // sequencer and ram port control
    always_comb begin
        n_state     = r_state;
        n_scan      = r_scan;
        n_pend      = 1'b0;
        n_pend_addr = r_pend_addr;
        n_hit       = r_hit;
        n_res       = r_res;
        n_ok        = r_ok;
        n_out_valid = r_out_valid && !i_ready;
        n_out_item  = r_out_item;
        ram_we      = 1'b0;
        ram_waddr   = r_item.entry_index[ADDR_W-1:0];
        ram_wdata   = r_item.entry_value;
        ram_re      = 1'b0;
        ram_raddr   = r_scan[ADDR_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_scan = '0;
                    unique case (i_item.func)
                        FUNC_LOAD:  n_state = S_LOAD;
                        FUNC_ALLOC: n_state = S_SCAN;
                        FUNC_NEXT:  n_state = S_NRD;
                        default: begin
                            n_res   = '0;
                            n_ok    = 1'b0;
                            n_state = S_RESP;
                        end
                    endcase
                end
            end
            S_LOAD: begin
                ram_we  = idx_in_table;
                n_res   = '0;
                n_ok    = idx_in_table;
                n_state = S_RESP;
            end
            S_NRD: begin
                ram_raddr = r_item.entry_index[ADDR_W-1:0];
                if (idx_in_lim) begin
                    ram_re  = 1'b1;
                    n_state = S_NWAIT;
                end else begin
                    n_res   = '0;
                    n_ok    = 1'b0;
                    n_state = S_RESP;
                end
            end
            S_NWAIT: begin
                n_res   = (ram_rdata == END_OF_CHAIN) ? '0 : ram_rdata;
                n_ok    = 1'b1;
                n_state = S_RESP;
            end
            S_SCAN: begin
                // one read issued per cycle, its data checked in the following cycle
                if (r_pend && ram_rdata == '0) begin
                    n_hit   = r_pend_addr;
                    n_state = S_LINK;
                end else if (!issue && !r_pend) begin
                    n_res   = END_OF_CHAIN;
                    n_ok    = 1'b0;
                    n_state = S_RESP;
                end else begin
                    ram_re      = issue;
                    n_pend      = issue;
                    n_pend_addr = r_scan[ADDR_W-1:0];
                    n_scan      = issue ? r_scan + LIM_W'(1) : r_scan;
                end
            end
            S_LINK: begin
                // link goes first so a self link ends up end of chain
                ram_we    = link_ok;
                ram_waddr = r_item.link_from[ADDR_W-1:0];
                ram_wdata = DATA_W'(r_hit);
                n_state   = S_MARK;
            end
            S_MARK: begin
                ram_we    = 1'b1;
                ram_waddr = r_hit;
                ram_wdata = END_OF_CHAIN;
                n_res     = DATA_W'(r_hit);
                n_ok      = 1'b1;
                n_state   = S_RESP;
            end
            S_RESP: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid            = 1'b1;
                    n_out_item.cluster_out = r_res;
                    n_out_item.success     = r_ok;
                    n_state                = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_scan      <= n_scan;
        r_pend_addr <= n_pend_addr;
        r_hit       <= n_hit;
        r_res       <= n_res;
        r_ok        <= n_ok;
        r_out_item  <= n_out_item;
    end

    // cluster table storage
    fct_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (DATA_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule

/* sim/tb_fat16_cluster_table.sv */
// self-checking testbench for the fat16 cluster table: directed rows, then random phases
`timescale 1ns / 100ps

module tb_fat16_cluster_table;
    import fct_pkg::*;

    // run shape
    localparam int RESET_CYCLES    = 7;
    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int TAIL_CYCLES     = 16;
    localparam int WATCHDOG_LIMIT  = 20000;

    // func 3 has no operation behind it
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // block ports
    logic             i_clk;
    logic             i_rst_n    = 1'b0;
    logic             i_valid    = 1'b0;
    logic             o_ready;
    t_in_item         i_item     = '0;
    logic             o_valid;
    logic             i_ready    = 1'b0;
    t_out_item        o_item;
    logic             i_cfg_we   = 1'b0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    // one directed row: optional limit change, the item, and a hand-written answer if any
    typedef struct {
        logic [CFG_W-1:0] set_limit;
        t_in_item         item;
        bit               typed;
        t_out_item        res;
    } t_dir_row;

    t_dir_row dir_rows[$];

    // mirror of the cluster table and its limit register
    logic [DATA_W-1:0] fat_mirror [TABLE_DEPTH];
    bit                fat_written [TABLE_DEPTH];
    int                written_list[$];
    int                cfg_entries = RESET_ENTRIES;
    int                chain_tail = 0;
    int                chain_cursor = 0;

    // results still owed by the block, oldest first
    t_out_item exp_results[$];

    // idling controls and statistics
    bit gaps_on   = 1'b1;
    bit stalls_on = 1'b1;
    int err_count = 0;
    int checked = 0;
    int n_loads = 0, n_allocs = 0, n_full = 0, n_next = 0, n_unused = 0;
    int stall_left = 0;
    int idle_cycles = 0;

    fat16_cluster_table u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_item     (o_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // limit as the block applies it
    function automatic int eff_limit();
        return (cfg_entries > TABLE_DEPTH) ? TABLE_DEPTH : cfg_entries;
    endfunction

    function automatic void fat_store(input int idx, input logic [DATA_W-1:0] v);
        fat_mirror[idx] = v;
        if (!fat_written[idx]) begin
            fat_written[idx] = 1'b1;
            written_list.push_back(idx);
        end
    endfunction

    // walk the active range like allocate does, stop at a free or an unwritten entry
    function automatic void scan_free(input int lim, output int unwritten_at, output int free_at);
        int pos;
        bit stop;
        unwritten_at = -1;
        free_at = -1;
        pos = 0;
        stop = 1'b0;
        while (!stop && pos < lim) begin
            if (!fat_written[pos]) begin
                unwritten_at = pos;
                stop = 1'b1;
            end else if (fat_mirror[pos] == '0) begin
                free_at = pos;
                stop = 1'b1;
            end else begin
                pos++;
            end
        end
    endfunction

    // expected result of one item, updating the mirror
    function automatic t_out_item fat_apply(input t_in_item it);
        t_out_item r;
        int lim;
        int pos;
        bit hit;
        lim = eff_limit();
        r.cluster_out = '0;
        r.success = 1'b0;
        case (it.func)
            FUNC_LOAD: begin
                if (it.entry_index < TABLE_DEPTH) begin
                    fat_store(int'(it.entry_index), it.entry_value);
                    r.success = 1'b1;
                end
            end
            FUNC_ALLOC: begin
                pos = 0;
                hit = 1'b0;
                while (!hit && pos < lim) begin
                    if (fat_mirror[pos] == '0) hit = 1'b1;
                    else pos++;
                end
                if (hit) begin
                    // link goes in first so a self link ends up as end of chain
                    if (it.link_from != 0 && it.link_from < lim)
                        fat_store(int'(it.link_from), DATA_W'(pos));
                    fat_store(pos, END_OF_CHAIN);
                    r.cluster_out = DATA_W'(pos);
                    r.success = 1'b1;
                    chain_tail = pos;
                end else begin
                    r.cluster_out = END_OF_CHAIN;
                end
            end
            FUNC_NEXT: begin
                if (it.entry_index < lim) begin
                    r.cluster_out = (fat_mirror[it.entry_index] == END_OF_CHAIN) ?
                                    '0 : fat_mirror[it.entry_index];
                    r.success = 1'b1;
                    chain_cursor = int'(r.cluster_out);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // random item that never makes the block read an unwritten entry
    function automatic t_in_item make_item();
        t_in_item it;
        int lim, win, gap_at, free_at, idx, k;
        lim = eff_limit();
        win = (lim < 64) ? lim : 64;
        it.func = FUNC_UNUSED;
        it.entry_index = DATA_W'($urandom);
        it.entry_value = DATA_W'($urandom);
        it.link_from = DATA_W'($urandom);
        k = $urandom_range(99);
        if (k < 30) begin
            it.func = FUNC_LOAD;
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: idx = $urandom_range(win - 1);
                6:       idx = $urandom_range(lim - 1);
                7:       idx = (lim < TABLE_DEPTH) ? $urandom_range(TABLE_DEPTH - 1, lim) :
                                                     TABLE_DEPTH - 1;
                default: idx = $urandom_range(65535);
            endcase
            it.entry_index = DATA_W'(idx);
            case ($urandom_range(6))
                0, 1, 2: it.entry_value = '0;
                3:       it.entry_value = END_OF_CHAIN;
                default: ;
            endcase
        end else if (k < 65) begin
            scan_free(lim, gap_at, free_at);
            if (gap_at >= 0) begin
                // fill the hole the scan would hit, mostly as a free entry
                it.func = FUNC_LOAD;
                it.entry_index = DATA_W'(gap_at);
                if ($urandom_range(3) != 0) it.entry_value = '0;
            end else begin
                it.func = FUNC_ALLOC;
                case ($urandom_range(10))
                    0, 1, 2, 3: it.link_from = DATA_W'(chain_tail);
                    4, 5:       it.link_from = '0;
                    6, 7:       it.link_from = DATA_W'($urandom_range(lim - 1));
                    8:          it.link_from = DATA_W'((free_at >= 0) ? free_at : lim);
                    9:          it.link_from = DATA_W'(lim);
                    default: ;
                endcase
            end
        end else if (k < 95) begin
            it.func = FUNC_NEXT;
            idx = -1;
            k = $urandom_range(9);
            if (k < 4 && chain_cursor != 0 && chain_cursor < lim && fat_written[chain_cursor])
                idx = chain_cursor;
            else if (k < 8 && written_list.size() != 0)
                repeat (8) begin
                    gap_at = written_list[$urandom_range(written_list.size() - 1)];
                    if (idx < 0 && gap_at < lim) idx = gap_at;
                end
            if (idx < 0) idx = $urandom_range(65535, lim);
            it.entry_index = DATA_W'(idx);
        end
        return it;
    endfunction

    function automatic int idle_len();
        return ($urandom_range(99) < 80) ? $urandom_range(3, 1) : $urandom_range(40, 8);
    endfunction

    function automatic void add_row(input logic [CFG_W-1:0] set_limit, input logic [1:0] func,
                                    input logic [DATA_W-1:0] idx, input logic [DATA_W-1:0] val,
                                    input logic [DATA_W-1:0] link, input bit typed,
                                    input logic [DATA_W-1:0] cl, input logic ok);
        t_dir_row row;
        row.set_limit = set_limit;
        row.item.func = func;
        row.item.entry_index = idx;
        row.item.entry_value = val;
        row.item.link_from = link;
        row.typed = typed;
        row.res.cluster_out = cl;
        row.res.success = ok;
        dir_rows.push_back(row);
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        err_count++;
        $display("mismatch at result %0d: %s got %0h want %0h", checked, what, got, want);
    endtask

    // present one item and return at the edge where it is accepted
    task automatic send_item(input t_in_item it);
        int gap;
        gap = (gaps_on && $urandom_range(99) < 35) ? idle_len() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic issue(input t_in_item it, input bit typed, input t_out_item typed_res);
        t_out_item want;
        send_item(it);
        want = fat_apply(it);
        case (it.func)
            FUNC_LOAD:  n_loads++;
            FUNC_ALLOC: begin
                n_allocs++;
                if (!want.success) n_full++;
            end
            FUNC_NEXT:  n_next++;
            default:    n_unused++;
        endcase
        if (typed) want = typed_res;
        exp_results.push_back(want);
    endtask

    // write the limit once the block has drained
    task automatic set_entries(input logic [CFG_W-1:0] v);
        i_valid <= 1'b0;
        while (exp_results.size() != 0) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_entries = int'(v);
    endtask

    // result sink with random back-pressure
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_ready <= 1'b0;
            stall_left = stall_left - 1;
        end else if (stalls_on && $urandom_range(99) < 30) begin
            i_ready <= 1'b0;
            stall_left = idle_len() - 1;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid && i_ready) begin
            if (exp_results.size() == 0) begin
                flag_mismatch("result with nothing expected, cluster_out", o_item.cluster_out, 0);
            end else begin
                want = exp_results.pop_front();
                if (o_item.cluster_out !== want.cluster_out)
                    flag_mismatch("cluster_out", o_item.cluster_out, want.cluster_out);
                if (o_item.success !== want.success)
                    flag_mismatch("success", o_item.success, want.success);
            end
            checked++;
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("no item moved for %0d cycles, %0d results outstanding",
                     WATCHDOG_LIMIT, exp_results.size());
            $display("tb_fat16_cluster_table failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // stimulus
    initial begin
        logic [CFG_W-1:0] lim_pick;
        int ph;
        foreach (fat_mirror[k]) begin
            fat_mirror[k] = '0;
            fat_written[k] = 1'b0;
        end

        // directed rows, limit starts at its reset value of 4096
        add_row(0, FUNC_LOAD,   16'd0,    16'hFFFF, 16'd0,    1, 16'd0,    1'b1);
        add_row(0, FUNC_LOAD,   16'd1,    16'hFFFF, 16'd0,    1, 16'd0,    1'b1);
        add_row(0, FUNC_LOAD,   16'd2,    16'h0000, 16'd0,    1, 16'd0,    1'b1);
        add_row(0, FUNC_LOAD,   16'd4095, 16'h1234, 16'd0,    1, 16'd0,    1'b1);
        // loads past the table depth are dropped
        add_row(0, FUNC_LOAD,   16'd4096, 16'hAAAA, 16'd0,    1, 16'd0,    1'b0);
        add_row(0, FUNC_LOAD,   16'hFFFF, 16'h5555, 16'hFFFF, 1, 16'd0,    1'b0);
        // end of chain reads back as 0
        add_row(0, FUNC_NEXT,   16'd0,    16'd0,    16'd0,    1, 16'd0,    1'b1);
        add_row(0, FUNC_NEXT,   16'd4095, 16'd0,    16'd0,    1, 16'h1234, 1'b1);
        add_row(0, FUNC_NEXT,   16'd4096, 16'd0,    16'd0,    1, 16'd0,    1'b0);
        add_row(0, FUNC_NEXT,   16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 16'd0,    1'b0);
        add_row(0, FUNC_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 16'd0,    1'b0);
        // allocate without link, then chained
        add_row(0, FUNC_ALLOC,  16'd0,    16'd0,    16'd0,    0, 16'd0,    1'b0);
        add_row(0, FUNC_LOAD,   16'd3,    16'h0000, 16'd0,    1, 16'd0,    1'b1);
        add_row(0, FUNC_ALLOC,  16'd0,    16'd0,    16'd2,    0, 16'd0,    1'b0);
        add_row(0, FUNC_NEXT,   16'd2,    16'd0,    16'd0,    0, 16'd0,    1'b0);
        // link to the cluster being allocated
        add_row(0, FUNC_LOAD,   16'd4,    16'h0000, 16'd0,    1, 16'd0,    1'b1);
        add_row(0, FUNC_ALLOC,  16'd0,    16'd0,    16'd4,    0, 16'd0,    1'b0);
        add_row(0, FUNC_NEXT,   16'd4,    16'd0,    16'd0,    0, 16'd0,    1'b0);
        // link beyond the limit is ignored
        add_row(0, FUNC_LOAD,   16'd5,    16'h0000, 16'd0,    1, 16'd0,    1'b1);
        add_row(0, FUNC_ALLOC,  16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 16'd0,    1'b0);
        // link at the last entry
        add_row(0, FUNC_LOAD,   16'd6,    16'h0000, 16'd0,    1, 16'd0,    1'b1);
        add_row(0, FUNC_ALLOC,  16'd0,    16'd0,    16'd4095, 0, 16'd0,    1'b0);
        add_row(0, FUNC_NEXT,   16'd4095, 16'd0,    16'd0,    0, 16'd0,    1'b0);
        // limit of 2: table full, then index at the limit
        add_row(2, FUNC_ALLOC,  16'd0,    16'd0,    16'd1,    1, END_OF_CHAIN, 1'b0);
        add_row(0, FUNC_NEXT,   16'd1,    16'd0,    16'd0,    1, 16'd0,    1'b1);
        add_row(0, FUNC_NEXT,   16'd2,    16'd0,    16'd0,    1, 16'd0,    1'b0);
        add_row(0, FUNC_LOAD,   16'd0,    16'h0000, 16'd0,    1, 16'd0,    1'b1);
        add_row(0, FUNC_ALLOC,  16'd0,    16'd0,    16'd1,    0, 16'd0,    1'b0);
        add_row(0, FUNC_NEXT,   16'd1,    16'd0,    16'd0,    0, 16'd0,    1'b0);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) begin
            if (dir_rows[k].set_limit != 0) set_entries(dir_rows[k].set_limit);
            issue(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].res);
        end

        // random phases, each under its own limit and idling mix
        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       lim_pick = 13'd2;
                1:       lim_pick = 13'd8191;
                2:       lim_pick = 13'd4096;
                3:       lim_pick = 13'd3;
                default: begin
                    case ($urandom_range(3))
                        0:       lim_pick = CFG_W'($urandom_range(40, 2));
                        1:       lim_pick = CFG_W'($urandom_range(300, 2));
                        2:       lim_pick = CFG_W'($urandom_range(8191, 4097));
                        default: lim_pick = CFG_W'($urandom_range(4096, 2));
                    endcase
                end
            endcase
            set_entries(lim_pick);
            gaps_on = (ph % 3 != 1);
            stalls_on = (ph % 4 != 2);
            repeat (ITEMS_PER_PHASE) issue(make_item(), 1'b0, '0);
        end

        // drain and let the pipeline settle
        i_valid <= 1'b0;
        while (exp_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("ran %0d loads, %0d allocates (%0d on a full table), %0d next reads, %0d unused",
                 n_loads, n_allocs, n_full, n_next, n_unused);
        $display("checked %0d results over %0d limit settings, %0d mismatches",
                 checked, PHASES + 2, err_count);
        if (err_count == 0) begin
            $display("tb_fat16_cluster_table passed");
        end else begin
            $display("tb_fat16_cluster_table failed");
        end
        $finish;
    end

endmodule
